>>> design/larc_pkg.sv
// Shared types and constants for the aging raster cache.
package larc_pkg;

  localparam int unsigned DEFAULT_ENTRIES = 16;

  localparam int unsigned AGE_W     = 2;
  localparam int unsigned RASTER_W  = 7;
  localparam int unsigned SPRITE_W  = 8;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned OFFSET_W  = 20;
  localparam int unsigned CNT_CFG_W = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 32;

  localparam logic [AGE_W-1:0]     AGE_DEAD      = 2'd0;
  localparam logic [AGE_W-1:0]     AGE_FRESH     = 2'd2;
  localparam logic [SPRITE_W-1:0]  SPRITE_RESET  = 8'hFF;
  localparam logic [CNT_CFG_W-1:0] ENTRIES_RESET = 5'd16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROM_BASE       = 1'd1;

  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_FILLED = 2'd1,
    ST_FULL   = 2'd2,
    ST_TICK   = 2'd3
  } status_e;

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_TICK   = 1'b1
  } action_e;

  // request token walking down the cell chain
  typedef struct packed {
    logic                vld;
    action_e             act;
    logic                hit;
    logic                free;
    logic [RASTER_W-1:0] raster;
    logic [SPRITE_W-1:0] sprite;
  } tok_t;

  // fill write broadcast from the chain end
  typedef struct packed {
    logic                en;
    logic [RASTER_W-1:0] raster;
    logic [SPRITE_W-1:0] sprite;
  } fill_t;

endpackage

>>> design/lazy_aging_raster_cache.sv
// Top level of the aging raster cache: request intake, cell chain, result and fill.
//
// Usage:
//  - Command channel: raise start with action_i and the lookup fields; the command
//    transfers at the rising edge where start is high and busy is low.
//  - action_i = lookup searches entries 0..entries_in_use-1 for a live match on
//    raster_index_i and sprite_id_i. A hit renews the entry age; a miss fills the
//    lowest dead entry and reports fetch_address_o / fetch_size_o from
//    load_descriptor_i; no dead entry reports full. action_i = tick ages entries.
//  - Result: done_o pulses for one cycle with status_o, slot_o, fetch_address_o and
//    fetch_size_o. The receiver cannot stall; the result must be taken that cycle.
//  - Chain: the request token walks the chain one cell per cycle; done_o is registered
//    from the token leaving the chain end. One command is in flight at a time; busy
//    stays high until the token leaves the chain end, so a new command cannot transfer
//    before then.
//  - Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 entries_in_use,
//    1 rom_base); write only while busy is low.
//  - Reset: all entries dead, raster keys 0, sprite keys 255, entries_in_use = 16,
//    rom_base = 0.
module lazy_aging_raster_cache #(
  parameter int unsigned CACHE_ENTRIES = larc_pkg::DEFAULT_ENTRIES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action_i,
  input  logic [larc_pkg::RASTER_W-1:0]   raster_index_i,
  input  logic [larc_pkg::SPRITE_W-1:0]   sprite_id_i,
  input  logic [larc_pkg::ADDR_W-1:0]     load_descriptor_i,
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic [larc_pkg::SLOT_W-1:0]     slot_o,
  output logic [larc_pkg::ADDR_W-1:0]     fetch_address_o,
  output logic [larc_pkg::SIZE_W-1:0]     fetch_size_o,
  input  logic                            cfg_we_i,
  input  logic [larc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [larc_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import larc_pkg::*;

  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam int unsigned CMP_W = 8;

  // configuration registers
  logic [CNT_CFG_W-1:0] entries_q;
  logic [ADDR_W-1:0]    rom_base_q;
  logic [CNT_W-1:0]     act_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q  <= ENTRIES_RESET;
      rom_base_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENTRIES_IN_USE: entries_q  <= cfg_wdata_i[CNT_CFG_W-1:0];
        REG_ROM_BASE:       rom_base_q <= cfg_wdata_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // entries_in_use above the cache size acts as the cache size
  always_comb begin
    if (CMP_W'(entries_q) > CMP_W'(CACHE_ENTRIES)) begin
      act_cnt = CNT_W'(CACHE_ENTRIES);
    end else begin
      act_cnt = CNT_W'(entries_q);
    end
  end

  // command intake
  logic        accept;
  logic        busy_q, busy_d;
  tok_t        tok0_q, tok0_d;
  logic [ADDR_W-1:0] desc_q;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  // chain wiring: index k feeds cell k, index CACHE_ENTRIES is the chain end
  tok_t             tok_w  [CACHE_ENTRIES+1];
  logic [IDX_W-1:0] hidx_w [CACHE_ENTRIES+1];
  logic [IDX_W-1:0] fidx_w [CACHE_ENTRIES+1];
  logic [CACHE_ENTRIES:0] vld_vec;
  fill_t            fill;
  logic [IDX_W-1:0] fill_idx;
  tok_t             tok_end;

  assign tok_w[0]  = tok0_q;
  assign hidx_w[0] = '0;
  assign fidx_w[0] = '0;
  assign tok_end   = tok_w[CACHE_ENTRIES];

  always_comb begin
    tok0_d        = '0;
    tok0_d.vld    = accept;
    tok0_d.act    = action_e'(action_i);
    tok0_d.raster = raster_index_i;
    tok0_d.sprite = sprite_id_i;
    busy_d        = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (tok_end.vld) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      tok0_q <= '0;
    end else begin
      busy_q <= busy_d;
      tok0_q <= tok0_d;
    end
  end

  // descriptor is only needed at the chain end
  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q <= load_descriptor_i;
    end
  end

  for (genvar k = 0; k < CACHE_ENTRIES; k++) begin : g_cell
    larc_cell #(
      .CELL_IDX (k),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .act_cnt_i  (act_cnt),
      .tok_i      (tok_w[k]),
      .hit_idx_i  (hidx_w[k]),
      .free_idx_i (fidx_w[k]),
      .fill_i     (fill),
      .fill_idx_i (fill_idx),
      .tok_o      (tok_w[k+1]),
      .hit_idx_o  (hidx_w[k+1]),
      .free_idx_o (fidx_w[k+1])
    );
  end

  for (genvar k = 0; k <= CACHE_ENTRIES; k++) begin : g_vld
    assign vld_vec[k] = tok_w[k].vld;
  end

  // chain end: decide the result; a miss with a dead entry broadcasts the fill
  status_e           status_d;
  logic [SLOT_W-1:0] slot_d;
  logic [ADDR_W-1:0] addr_d;
  logic [SIZE_W-1:0] size_d;

  always_comb begin
    fill.en     = 1'b0;
    fill.raster = tok_end.raster;
    fill.sprite = tok_end.sprite;
    fill_idx    = fidx_w[CACHE_ENTRIES];
    status_d    = ST_FULL;
    slot_d      = '0;
    addr_d      = '0;
    size_d      = '0;
    if (tok_end.act == ACT_TICK) begin
      status_d = ST_TICK;
    end else if (tok_end.hit) begin
      status_d = ST_HIT;
      slot_d   = SLOT_W'(hidx_w[CACHE_ENTRIES]);
    end else if (tok_end.free) begin
      fill.en  = tok_end.vld;
      status_d = ST_FILLED;
      slot_d   = SLOT_W'(fidx_w[CACHE_ENTRIES]);
      addr_d   = rom_base_q + ADDR_W'(desc_q[OFFSET_W-1:0]);
      size_d   = {desc_q[ADDR_W-1:OFFSET_W], 4'b0000};
    end
  end

  logic              done_q;
  status_e           status_q;
  logic [SLOT_W-1:0] slot_q;
  logic [ADDR_W-1:0] addr_q;
  logic [SIZE_W-1:0] size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tok_end.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_end.vld) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      addr_q   <= addr_d;
      size_q   <= size_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign slot_o          = slot_q;
  assign fetch_address_o = addr_q;
  assign fetch_size_o    = size_q;

  // at most one command travels the chain
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_vec) <= 1)
    else $error("more than one token in the cell chain");

  // nothing in flight while idle
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (vld_vec == '0))
    else $error("token in chain while not busy");

  // a fill always shows up as a filled result next cycle
  a_fill_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill.en |=> (done_o && (status_o == ST_FILLED)))
    else $error("fill without filled result");

  // every token leaving the chain produces a result
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_end.vld |=> done_o)
    else $error("chain end token produced no result");

endmodule

>>> design/larc_cell.sv
// One cache entry cell: holds age and keys; the passing token updates the age, the fill broadcast writes age and keys.
module larc_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CNT_W    = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CNT_W-1:0]  act_cnt_i,
  input  larc_pkg::tok_t    tok_i,
  input  logic [IDX_W-1:0]  hit_idx_i,
  input  logic [IDX_W-1:0]  free_idx_i,
  input  larc_pkg::fill_t   fill_i,
  input  logic [IDX_W-1:0]  fill_idx_i,
  output larc_pkg::tok_t    tok_o,
  output logic [IDX_W-1:0]  hit_idx_o,
  output logic [IDX_W-1:0]  free_idx_o
);
  import larc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

  logic [AGE_W-1:0]    age_q, age_d;
  logic [RASTER_W-1:0] raster_q, raster_d;
  logic [SPRITE_W-1:0] sprite_q, sprite_d;
  tok_t                tok_q, tok_d;
  logic [IDX_W-1:0]    hidx_q, hidx_d;
  logic [IDX_W-1:0]    fidx_q, fidx_d;

  logic in_use, live, match;

  assign in_use = MY_CNT < act_cnt_i;
  assign live   = age_q != AGE_DEAD;
  assign match  = (raster_q == tok_i.raster) && (sprite_q == tok_i.sprite);

  always_comb begin
    age_d    = age_q;
    raster_d = raster_q;
    sprite_d = sprite_q;
    tok_d    = tok_i;
    hidx_d   = hit_idx_i;
    fidx_d   = free_idx_i;
    if (tok_i.vld && in_use) begin
      if (tok_i.act == ACT_TICK) begin
        if (live) begin
          age_d = age_q - AGE_W'(1);
        end
      end else if (live && match && !tok_i.hit) begin
        age_d     = AGE_FRESH;
        tok_d.hit = 1'b1;
        hidx_d    = MY_IDX;
      end else if (!live && !tok_i.free) begin
        tok_d.free = 1'b1;
        fidx_d     = MY_IDX;
      end
    end
    if (fill_i.en && (fill_idx_i == MY_IDX)) begin
      age_d    = AGE_FRESH;
      raster_d = fill_i.raster;
      sprite_d = fill_i.sprite;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q    <= AGE_DEAD;
      raster_q <= '0;
      sprite_q <= SPRITE_RESET;
      tok_q    <= '0;
    end else begin
      age_q    <= age_d;
      raster_q <= raster_d;
      sprite_q <= sprite_d;
      tok_q    <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hidx_q <= hidx_d;
    fidx_q <= fidx_d;
  end

  assign tok_o      = tok_q;
  assign hit_idx_o  = hidx_q;
  assign free_idx_o = fidx_q;

endmodule
